// ----- design/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the sequential list engine: list capacity,
// field widths, request codes and the structs that run between the cells,
// the group reducers and the top level.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int CAPACITY    = 64;
   localparam int DATA_W      = 32;
   localparam int POS_W       = 7;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int LEN_W       = $clog2(CAPACITY + 1);
   localparam int CMP_W       = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

   // The hit flags and delete taps of the cells are reduced in groups.
   localparam int GROUP_SIZE  = 8;
   localparam int GRP_IDX_W   = $clog2(GROUP_SIZE);
   localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_CAP     = NUM_GROUPS * GROUP_SIZE;
   localparam int NG_W        = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOCATE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Broadcast to every cell in the cycle a request is taken.
   typedef struct packed {
      logic             do_insert;
      logic             do_delete;
      logic             do_locate;
      logic [IDX_W-1:0] pos_idx;
      logic [LEN_W-1:0] length;
      data_type         value;
   } cell_ctrl_type;

   // Registered summary of one group of cells.
   typedef struct packed {
      logic                 any_hit;
      logic [GRP_IDX_W-1:0] first_hit;
      data_type             removed;
   } grp_sum_type;

   // Per-request bookkeeping that follows the item down the pipeline.
   typedef struct packed {
      logic             is_locate;
      logic             ok;
      logic [LEN_W-1:0] length;
   } meta_type;

endpackage

// ----- design/sle_req_if.sv -----
// ----------------------------------------------------------------------------
// sle_req_if
// Request channel: valid/ready handshake carrying one list operation.
// ----------------------------------------------------------------------------
interface sle_req_if;

   logic                 valid;
   logic                 ready;
   logic [1:0]           req_type;
   logic [sle_pkg::POS_W-1:0] position;
   sle_pkg::data_type    value;

   modport source (output valid, output req_type, output position, output value,
                   input ready);
   modport sink   (input valid, input req_type, input position, input value,
                   output ready);

endinterface

// ----- design/sle_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sle_rsp_if
// Response channel: valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface sle_rsp_if;

   logic                      valid;
   logic                      ready;
   logic                      success;
   logic [sle_pkg::POS_W-1:0] found_position;
   sle_pkg::data_type         removed_value;
   logic [sle_pkg::POS_W-1:0] list_length;

   modport source (output valid, output success, output found_position,
                   output removed_value, output list_length, input ready);
   modport sink   (input valid, input success, input found_position,
                   input removed_value, input list_length, output ready);

endinterface

// ----- design/sle_cell.sv -----
// ----------------------------------------------------------------------------
// sle_cell
// One list slot. Holds one entry, shifts with its neighbors on insert and
// delete, and registers its own locate hit and delete tap.
// ----------------------------------------------------------------------------
module sle_cell (
   input  logic                       clock,
   input  logic [sle_pkg::IDX_W-1:0]  cell_idx,
   input  sle_pkg::cell_ctrl_type     ctrl,
   input  sle_pkg::data_type          left_entry,
   input  sle_pkg::data_type          right_entry,
   output sle_pkg::data_type          entry,
   output logic                       hit,
   output sle_pkg::data_type          tap
);

   sle_pkg::data_type entry_ff, entry_in;
   logic              hit_ff, hit_in;
   sle_pkg::data_type tap_ff, tap_in;
   logic              at_pos, past_pos, in_list;

   always_comb begin
      at_pos   = (cell_idx == ctrl.pos_idx);
      past_pos = (cell_idx > ctrl.pos_idx);
      in_list  = (sle_pkg::LEN_W'(cell_idx) < ctrl.length);

      entry_in = entry_ff;
      if (ctrl.do_insert) begin
         if (at_pos) begin
            entry_in = ctrl.value;
         end else if (past_pos) begin
            entry_in = left_entry;
         end
      end else if (ctrl.do_delete && (at_pos || past_pos)) begin
         entry_in = right_entry;
      end

      hit_in = ctrl.do_locate && in_list && (entry_ff == ctrl.value);
      tap_in = (ctrl.do_delete && at_pos) ? entry_ff : '0;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
      tap_ff   <= tap_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;
   assign tap   = tap_ff;

endmodule

// ----- design/sle_group.sv -----
// ----------------------------------------------------------------------------
// sle_group
// Reduces the hit flags and delete taps of one group of cells into a
// registered summary: any hit, lowest hit index and the removed value.
// ----------------------------------------------------------------------------
module sle_group (
   input  logic                              clock,
   input  logic                              load,
   input  logic [sle_pkg::GROUP_SIZE-1:0]    hit,
   input  sle_pkg::data_type                 tap [sle_pkg::GROUP_SIZE],
   output sle_pkg::grp_sum_type              sum
);

   sle_pkg::grp_sum_type sum_ff, sum_in;

   always_comb begin
      sum_in.any_hit   = |hit;
      sum_in.first_hit = '0;
      sum_in.removed   = '0;
      // Walk downward so the lowest hit wins.
      for (int i = sle_pkg::GROUP_SIZE - 1; i >= 0; i--) begin
         if (hit[i]) begin
            sum_in.first_hit = sle_pkg::GRP_IDX_W'(i);
         end
      end
      for (int i = 0; i < sle_pkg::GROUP_SIZE; i++) begin
         sum_in.removed = sum_in.removed | tap[i];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ----- design/sequential_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// sequential_list_engine_core
// Bounded ordered list of signed words with insert, delete and locate,
// built as a row of cells that shift and compare in parallel.
// ----------------------------------------------------------------------------
//
//   channel   direction   beat contents
//   -------   ---------   -----------------------------------------------
//   req_bus   in          req_type, position, value
//   rsp_bus   out         success, found_position, removed_value, list_length
//
// A result reaches the output register through registered steps: the
// cells shift and compare at the accept edge, the group reducers register
// their summaries on the next edge, and the final group-to-list reduction
// is loaded into the output register once that register is free. The next
// request is taken only after the result has left the group stage, so the
// block holds one request at a time.
// A response waiting on rsp_bus does not block the next beat until that
// beat itself needs the output register; from then on the beat waits in
// the group stage for as long as rsp_bus stalls.
// Reset clears the list length and all valid flags and holds req_bus.ready
// low; entry contents are not reset, since only slots below the length are
// ever read.
//
module sequential_list_engine_core (
   input  logic          clock,
   input  logic          reset,
   sle_req_if.sink       req_bus,
   sle_rsp_if.source     rsp_bus
);

   // ---------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------
   logic [sle_pkg::LEN_W-1:0] length_ff, length_in;
   logic                      s1_valid_ff, s1_valid_in;
   logic                      s2_valid_ff, s2_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sle_pkg::meta_type         s1_meta_ff, s1_meta_in;
   sle_pkg::meta_type         s2_meta_ff;

   logic                      req_take;
   logic                      out_load;
   sle_pkg::cell_ctrl_type    ctrl;
   logic                      ins_ok, del_ok, is_locate;
   logic [sle_pkg::CMP_W-1:0] pos_w, len_w;

   // Output register.
   logic                      success_ff;
   logic [sle_pkg::POS_W-1:0] found_ff;
   sle_pkg::data_type         removed_ff;
   logic [sle_pkg::POS_W-1:0] list_len_ff;

   // The list is worked on one request at a time; the output register
   // decouples the response side.
   assign req_bus.ready = !reset && !(s1_valid_ff || s2_valid_ff);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_load      = s2_valid_ff && (!rsp_valid_ff || rsp_bus.ready);

   // ---------------------------------------------------------------------
   // Request decode. A failed insert or delete leaves the cells untouched.
   // ---------------------------------------------------------------------
   always_comb begin
      pos_w     = sle_pkg::CMP_W'(req_bus.position);
      len_w     = sle_pkg::CMP_W'(length_ff);
      ins_ok    = 1'b0;
      del_ok    = 1'b0;
      is_locate = 1'b0;
      unique case (sle_pkg::op_type'(req_bus.req_type))
         sle_pkg::OP_INSERT: begin
            ins_ok = (pos_w != '0) && (pos_w <= len_w + sle_pkg::CMP_W'(1)) &&
                     (len_w < sle_pkg::CMP_W'(sle_pkg::CAPACITY));
         end
         sle_pkg::OP_DELETE: begin
            del_ok = (pos_w != '0) && (pos_w <= len_w);
         end
         sle_pkg::OP_LOCATE: begin
            is_locate = 1'b1;
         end
         default: begin
            is_locate = 1'b0;
         end
      endcase

      ctrl.do_insert = req_take && ins_ok;
      ctrl.do_delete = req_take && del_ok;
      ctrl.do_locate = req_take && is_locate;
      ctrl.pos_idx   = sle_pkg::IDX_W'(req_bus.position - sle_pkg::POS_W'(1));
      ctrl.length    = length_ff;
      ctrl.value     = req_bus.value;

      length_in = length_ff;
      if (ctrl.do_insert) begin
         length_in = length_ff + sle_pkg::LEN_W'(1);
      end else if (ctrl.do_delete) begin
         length_in = length_ff - sle_pkg::LEN_W'(1);
      end

      s1_meta_in.is_locate = is_locate;
      s1_meta_in.ok        = ins_ok || del_ok;
      s1_meta_in.length    = length_in;

      s1_valid_in  = req_take;
      s2_valid_in  = s1_valid_ff || (s2_valid_ff && !out_load);
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_meta_ff <= s1_meta_in;
      end
      if (s1_valid_ff) begin
         s2_meta_ff <= s1_meta_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Row of cells. Each cell sees its two neighbors; the slots past the
   // capacity exist only as zero flags so the groups stay full.
   // ---------------------------------------------------------------------
   sle_pkg::data_type entry_q [sle_pkg::CAPACITY];
   logic [sle_pkg::PAD_CAP-1:0] hit_all;
   sle_pkg::data_type tap_all [sle_pkg::PAD_CAP];

   for (genvar i = 0; i < sle_pkg::PAD_CAP; i++) begin : g_cell
      if (i < sle_pkg::CAPACITY) begin : g_real
         sle_pkg::data_type left_d, right_d;
         if (i == 0) begin : g_first
            assign left_d = '0;
         end else begin : g_mid_l
            assign left_d = entry_q[i-1];
         end
         if (i == sle_pkg::CAPACITY - 1) begin : g_last
            assign right_d = '0;
         end else begin : g_mid_r
            assign right_d = entry_q[i+1];
         end
         sle_cell u_cell (
            .clock       (clock),
            .cell_idx    (sle_pkg::IDX_W'(i)),
            .ctrl        (ctrl),
            .left_entry  (left_d),
            .right_entry (right_d),
            .entry       (entry_q[i]),
            .hit         (hit_all[i]),
            .tap         (tap_all[i])
         );
      end else begin : g_pad
         assign hit_all[i] = 1'b0;
         assign tap_all[i] = '0;
      end
   end

   // ---------------------------------------------------------------------
   // First reduction level: one registered summary per group of cells.
   // ---------------------------------------------------------------------
   sle_pkg::grp_sum_type grp_sum [sle_pkg::NUM_GROUPS];

   for (genvar g = 0; g < sle_pkg::NUM_GROUPS; g++) begin : g_grp
      sle_pkg::data_type grp_tap [sle_pkg::GROUP_SIZE];
      for (genvar j = 0; j < sle_pkg::GROUP_SIZE; j++) begin : g_tap
         assign grp_tap[j] = tap_all[g*sle_pkg::GROUP_SIZE + j];
      end
      sle_group u_group (
         .clock (clock),
         .load  (s1_valid_ff),
         .hit   (hit_all[g*sle_pkg::GROUP_SIZE +: sle_pkg::GROUP_SIZE]),
         .tap   (grp_tap),
         .sum   (grp_sum[g])
      );
   end

   // ---------------------------------------------------------------------
   // Second reduction level: lowest group with a hit, and the OR of all
   // delete taps (at most one cell ever taps).
   // ---------------------------------------------------------------------
   logic                      any_hit;
   logic [sle_pkg::NG_W-1:0]  first_grp;
   logic [sle_pkg::GRP_IDX_W-1:0] first_in_grp;
   sle_pkg::data_type         removed_all;
   logic [sle_pkg::POS_W-1:0] found_pos;

   always_comb begin
      any_hit      = 1'b0;
      first_grp    = '0;
      first_in_grp = '0;
      removed_all  = '0;
      for (int g = sle_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_sum[g].any_hit) begin
            any_hit      = 1'b1;
            first_grp    = sle_pkg::NG_W'(g);
            first_in_grp = grp_sum[g].first_hit;
         end
      end
      for (int g = 0; g < sle_pkg::NUM_GROUPS; g++) begin
         removed_all = removed_all | grp_sum[g].removed;
      end
      found_pos = ((sle_pkg::POS_W'(first_grp) << sle_pkg::GRP_IDX_W) |
                   sle_pkg::POS_W'(first_in_grp)) + sle_pkg::POS_W'(1);
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (s2_meta_ff.is_locate) begin
            success_ff <= any_hit;
            found_ff   <= any_hit ? found_pos : '0;
         end else begin
            success_ff <= s2_meta_ff.ok;
            found_ff   <= '0;
         end
         removed_ff  <= removed_all;
         list_len_ff <= sle_pkg::POS_W'(s2_meta_ff.length);
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.success        = success_ff;
   assign rsp_bus.found_position = found_ff;
   assign rsp_bus.removed_value  = removed_ff;
   assign rsp_bus.list_length    = list_len_ff;

`ifndef SYNTHESIS
   // The list never grows past its capacity.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= sle_pkg::LEN_W'(sle_pkg::CAPACITY))
      else $error("list length above capacity");

   // Only one request is in the reduction pipeline at a time.
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s2_valid_ff))
      else $error("two requests in flight");

   // An accepted beat always passes through s1 and reaches the group stage (s2) without a stall.
   a_accept_advances: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff ##1 s2_valid_ff)
      else $error("accepted request lost in pipeline");

   // A length change happens only at an accepted beat.
   a_len_step: assert property (@(posedge clock) disable iff (reset)
      !req_take |=> $stable(length_ff))
      else $error("length changed without a request");
`endif

endmodule

// ----- dv/tb_sequential_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// tb_sequential_list_engine_core
// Self-checking bench for the sequential list engine. A directed table opens
// the run with empty-list, out-of-range and extreme-value requests. Random
// fill and drain sequences follow and push the list to full and back to empty
// several times. Results are checked against the table or a local list model.
// ----------------------------------------------------------------------------
module tb_sequential_list_engine_core;

   timeunit 1ns;
   timeprecision 1ps;

   import sle_pkg::*;

   localparam int RANDOM_BEATS = 1300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 8;
   localparam int MAX_REPORTS  = 30;

   // One result beat, laid out in the order of the response channel.
   typedef struct packed {
      logic             success;
      logic [POS_W-1:0] found_position;
      data_type         removed_value;
      logic [POS_W-1:0] list_length;
   } list_result_t;

   // One row of the directed table. When has_res is set, res is the answer
   // that can be read straight off the spec; otherwise the list model decides.
   typedef struct packed {
      op_type           op;
      logic [POS_W-1:0] pos;
      data_type         val;
      logic             has_res;
      list_result_t     res;
   } dir_row_t;

   localparam data_type     WORD_MAX  = 32'sh7FFF_FFFF;
   localparam data_type     WORD_MIN  = 32'sh8000_0000;
   localparam list_result_t NO_RES    = '0;
   localparam list_result_t REFUSED_0 = '{1'b0, 7'd0, 32'sd0, 7'd0};
   localparam list_result_t REFUSED_3 = '{1'b0, 7'd0, 32'sd0, 7'd3};

   localparam int NUM_DIRECTED = 25;
   localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
      // Everything that touches an empty list is refused or misses.
      '{OP_LOCATE, 7'd0,   32'sd0,   1'b1, REFUSED_0},
      '{OP_DELETE, 7'd1,   32'sd0,   1'b1, REFUSED_0},
      '{OP_INSERT, 7'd0,   32'sd5,   1'b1, REFUSED_0},
      '{OP_INSERT, 7'd2,   32'sd5,   1'b1, REFUSED_0},
      '{OP_NONE,   7'd127, -32'sd1,  1'b1, REFUSED_0},
      // Build the list from the extremes of the value range.
      '{OP_INSERT, 7'd1,   WORD_MAX, 1'b1, '{1'b1, 7'd0, 32'sd0, 7'd1}},
      '{OP_INSERT, 7'd2,   WORD_MIN, 1'b1, '{1'b1, 7'd0, 32'sd0, 7'd2}},
      '{OP_INSERT, 7'd1,   32'sd0,   1'b0, NO_RES},
      '{OP_LOCATE, 7'd0,   WORD_MIN, 1'b0, NO_RES},
      '{OP_LOCATE, 7'd9,   32'sd12345, 1'b0, NO_RES},
      // Out-of-range positions on a three-entry list.
      '{OP_INSERT, 7'd5,   32'sd7,   1'b1, REFUSED_3},
      '{OP_INSERT, 7'd127, 32'sd7,   1'b1, REFUSED_3},
      '{OP_DELETE, 7'd0,   32'sd0,   1'b1, REFUSED_3},
      '{OP_DELETE, 7'd4,   32'sd0,   1'b1, REFUSED_3},
      '{OP_NONE,   7'd2,   32'sd0,   1'b1, REFUSED_3},
      // Append at the tail, add a duplicate, then locate first matches.
      '{OP_INSERT, 7'd4,   -32'sd1,  1'b0, NO_RES},
      '{OP_INSERT, 7'd3,   32'sd0,   1'b0, NO_RES},
      '{OP_LOCATE, 7'd0,   32'sd0,   1'b0, NO_RES},
      '{OP_LOCATE, 7'd127, -32'sd1,  1'b0, NO_RES},
      // Delete from the middle, the head and the tail down to empty.
      '{OP_DELETE, 7'd3,   32'sd0,   1'b0, NO_RES},
      '{OP_DELETE, 7'd1,   32'sd0,   1'b0, NO_RES},
      '{OP_DELETE, 7'd3,   32'sd0,   1'b0, NO_RES},
      '{OP_LOCATE, 7'd0,   32'sd0,   1'b0, NO_RES},
      '{OP_DELETE, 7'd2,   32'sd0,   1'b0, NO_RES},
      '{OP_DELETE, 7'd1,   32'sd0,   1'b0, NO_RES}
   };

   logic clock;
   logic reset;

   sle_req_if req_if ();
   sle_rsp_if rsp_if ();

   sequential_list_engine_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // Local copy of the list. Only slots below list_len are ever read.
   data_type     list_mem [CAPACITY];
   int unsigned  list_len;

   // Results still owed by the block, oldest first.
   list_result_t owed_results [$];

   // Handshake between the stimulus process and the monitor.
   int unsigned  beats_in;
   logic         beat_has_res;
   list_result_t beat_res;
   bit           req_gaps_on;
   bit           rsp_stalls_on;
   int unsigned  rsp_hold;

   int unsigned  cycles;
   int unsigned  errors;
   int unsigned  inserts_ok, deletes_ok, locate_hits, full_refusals, fills;

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // List model: applies one request to the local list and returns the
   // result beat the block must produce for it. Insert and delete shift the
   // tail of the list by one slot; locate reports the first equal entry.
   // ------------------------------------------------------------------------
   function automatic list_result_t apply_list_op(input op_type op,
                                                  input int unsigned pos,
                                                  input data_type val);
      list_result_t r;
      r = '0;
      case (op)
         OP_INSERT: begin
            if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) begin
               for (int k = list_len; k >= int'(pos); k--)
                  list_mem[k] = list_mem[k-1];
               list_mem[pos-1] = val;
               list_len++;
               r.success = 1'b1;
            end
         end
         OP_DELETE: begin
            if (pos >= 1 && pos <= list_len) begin
               r.removed_value = list_mem[pos-1];
               for (int k = pos; k < int'(list_len); k++)
                  list_mem[k-1] = list_mem[k];
               list_len--;
               r.success = 1'b1;
            end
         end
         OP_LOCATE: begin
            for (int k = 0; k < int'(list_len); k++) begin
               if (!r.success && list_mem[k] == val) begin
                  r.success        = 1'b1;
                  r.found_position = POS_W'(k + 1);
               end
            end
         end
         default: begin
            // The unused request code leaves the list alone.
         end
      endcase
      r.list_length = POS_W'(list_len);
      return r;
   endfunction

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Values lean toward a small pool and toward entries already in the
   // list, so that locates hit and duplicates show up regularly.
   function automatic data_type pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 20 && list_len > 0) return list_mem[$urandom_range(0, list_len - 1)];
      if (r < 50) return data_type'($urandom_range(0, 8)) - 32'sd4;
      if (r < 60) return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
      return data_type'($urandom);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor. Runs at the rising edge and sees the values that were set up
   // before the edge. Results are checked before the new request is modeled;
   // the pipeline latency keeps a request from answering in its own cycle.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      list_result_t want;
      list_result_t model_res;
      if (!reset) begin
         cycles++;
         if (rsp_if.valid && rsp_if.ready) begin
            if (owed_results.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: result beat with nothing expected", $realtime);
            end else begin
               want = owed_results.pop_front();
               check_field("success", 32'(want.success), 32'(rsp_if.success));
               check_field("found_position", 32'(want.found_position),
                           32'(rsp_if.found_position));
               check_field("removed_value", want.removed_value, rsp_if.removed_value);
               check_field("list_length", 32'(want.list_length),
                           32'(rsp_if.list_length));
            end
         end
         if (req_if.valid && req_if.ready) begin
            if (op_type'(req_if.req_type) == OP_INSERT && list_len == CAPACITY)
               full_refusals++;
            model_res = apply_list_op(op_type'(req_if.req_type), req_if.position,
                                      req_if.value);
            if (model_res.success) begin
               case (op_type'(req_if.req_type))
                  OP_INSERT: begin
                     inserts_ok++;
                     if (list_len == CAPACITY) fills++;
                  end
                  OP_DELETE: deletes_ok++;
                  default:   locate_hits++;
               endcase
            end
            owed_results.push_back(beat_has_res ? beat_res : model_res);
            beats_in++;
         end
         if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding",
                     cycles, owed_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Result side: ready drops for random stretches while stalls are enabled.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold     <= 0;
      end else if (rsp_hold > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold     <= rsp_hold - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_hold     <= rsp_stalls_on ? pick_gap() : 0;
      end
   end

   // Present one request beat at a falling edge and hold it until the
   // monitor has seen it accepted, then idle for a while if gaps are on.
   task automatic drive_beat(input op_type op, input logic [POS_W-1:0] pos,
                             input data_type val, input logic has_res,
                             input list_result_t res);
      int unsigned target;
      int unsigned gap;
      target          = beats_in + 1;
      req_if.valid    = 1'b1;
      req_if.req_type = op;
      req_if.position = pos;
      req_if.value    = val;
      beat_has_res    = has_res;
      beat_res        = res;
      do @(negedge clock); while (beats_in != target);
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      op_type      op;
      int unsigned p;
      int unsigned r;
      bit          filling;

      clock           = 1'b0;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.req_type = OP_NONE;
      req_if.position = '0;
      req_if.value    = '0;
      rsp_if.ready    = 1'b0;
      beat_has_res    = 1'b0;
      beat_res        = '0;
      list_len        = 0;
      beats_in        = 0;
      cycles          = 0;
      errors          = 0;
      inserts_ok      = 0;
      deletes_ok      = 0;
      locate_hits     = 0;
      full_refusals   = 0;
      fills           = 0;
      req_gaps_on     = 1'b1;
      rsp_stalls_on   = 1'b1;
      filling         = 1'b1;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         drive_beat(DIRECTED[i].op, DIRECTED[i].pos, DIRECTED[i].val,
                    DIRECTED[i].has_res, DIRECTED[i].res);

      // Random part: alternate between filling the list to capacity and
      // draining it back to empty, so both boundaries are hit repeatedly.
      // A little noise (any code, any position) is mixed in throughout.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 100 == 0) begin
            // Some stretches run with no idling at all on one or both sides.
            req_gaps_on   = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
         end
         if (filling && list_len == CAPACITY && $urandom_range(0, 5) == 0)
            filling = 1'b0;
         else if (!filling && list_len == 0 && $urandom_range(0, 3) == 0)
            filling = 1'b1;

         r = $urandom_range(0, 99);
         if (r < 6) begin
            op = op_type'($urandom_range(0, 3));
            p  = $urandom_range(0, 127);
         end else begin
            if (r < (filling ? 66 : 30))      op = OP_INSERT;
            else if (r < (filling ? 80 : 80)) op = OP_DELETE;
            else                              op = OP_LOCATE;

            case (op)
               OP_INSERT: begin
                  r = $urandom_range(0, 99);
                  if (r < 12)      p = 1;
                  else if (r < 24) p = list_len + 1;
                  else if (r < 85) p = $urandom_range(1, list_len + 1);
                  else if (r < 92) p = 0;
                  else             p = $urandom_range(list_len + 2, 127);
               end
               OP_DELETE: begin
                  r = $urandom_range(0, 99);
                  if (list_len > 0 && r < 88) p = $urandom_range(1, list_len);
                  else if (r < 94)            p = 0;
                  else                        p = $urandom_range(list_len + 1, 127);
               end
               default: p = $urandom_range(0, 127);
            endcase
         end
         drive_beat(op, POS_W'(p), pick_value(), 1'b0, NO_RES);
      end

      // Drain: stalls stop so every owed result can come out.
      req_if.valid  = 1'b0;
      rsp_stalls_on = 1'b0;
      while (owed_results.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("%0d beats in %0d cycles: %0d inserts, %0d deletes, %0d locate hits",
               beats_in, cycles, inserts_ok, deletes_ok, locate_hits);
      $display("list filled to capacity %0d times, %0d inserts refused when full",
               fills, full_refusals);
      if (errors == 0 && owed_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/sle_pkg.sv
design/sle_req_if.sv
design/sle_rsp_if.sv
design/sle_cell.sv
design/sle_group.sv
design/sequential_list_engine_core.sv
dv/tb_sequential_list_engine_core.sv
